[hw/rtl/ssdrs_pkg.sv]
package ssdrs_pkg;

  localparam int RegEntries = 128;
  localparam int RegAddrW   = 7;
  localparam int DgBytes    = 5;

  localparam logic [1:0] OP_CS_ASSERT   = 2'd0;
  localparam logic [1:0] OP_CS_DEASSERT = 2'd1;
  localparam logic [1:0] OP_XFER        = 2'd2;

  localparam logic [0:0] CFG_DEVICE_PRESENT = 1'd0;
  localparam logic [0:0] CFG_VALID_IDENTITY = 1'd1;

  localparam logic [RegAddrW-1:0] ADDR_GSTAT      = 7'h01;
  localparam logic [RegAddrW-1:0] ADDR_IOIN       = 7'h04;
  localparam logic [RegAddrW-1:0] ADDR_DRV_STATUS = 7'h6f;

  localparam logic [31:0] IOIN_IDENTITY = (32'h11 << 24) | (32'h1 << 6);
  localparam logic [7:0]  STATUS_FAULT  = 8'h02;
  localparam logic [7:0]  MISO_IDLE     = 8'hff;

endpackage

[hw/rtl/spi_stepper_driver_register_slave.sv]
// SPI register slave for a stepper driver using 40-bit datagrams. Each input
// transaction is a chip-select assert, a chip-select deassert or a byte
// transfer; only byte transfers return a byte. A chip-select deassert that
// completes a five-byte datagram with the device present also passes
// through the FIN state, which performs the register write or read on the
// 128 x 32 register file (one synchronous port, registered read). A new
// transaction is taken once no datagram is finishing and the output
// register is free or being emptied. Register file entries read as zero
// until written (per-entry valid bits, cleared at reset), so no clearing
// pass is needed after reset.
module spi_stepper_driver_register_slave
  import ssdrs_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_idx_i,
  input  logic [0:0]  cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // opcode[1:0], mosi_byte[9:2], step_level[10], dir_level[11],
  // drive_enabled[12], driver_fault[13], over_temp[14], over_temp_warn[15],
  // undervoltage_set[16], zero[23:17]
  input  logic [23:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // miso_byte[7:0]
  output logic [7:0]  m_axis_tdata
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_FIN  = 1'b1;

  logic state_q, state_d;
  logic present_q, ident_q;
  logic selected_q;
  logic [2:0] count_q;
  logic [7:0] rx_q [DgBytes];
  logic [7:0] ans_q [DgBytes];
  logic [7:0] pend_q [DgBytes];
  logic uv_q;
  logic [RegEntries-1:0] valid_q;
  logic out_valid_q;
  logic [7:0] out_data_q;

  logic [31:0] mem [RegEntries];
  logic [31:0] rd_q;
  logic rd_valid_q;

  // live inputs of the deassert transaction
  logic step_q, dir_q, en_q, fault_q, ot_q, otw_q, uvset_q;

  logic [1:0] opcode;
  logic [7:0] mosi;
  logic accept;
  logic [RegAddrW-1:0] addr;
  logic [31:0] wval, rval;
  logic [2:0] ans_idx;
  logic mem_we;

  assign opcode = s_axis_tdata[1:0];
  assign mosi   = s_axis_tdata[9:2];
  assign s_axis_tready = (state_q == ST_IDLE) && (!out_valid_q || m_axis_tready);
  assign accept = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  assign addr = rx_q[0][RegAddrW-1:0];
  assign wval = {rx_q[1], rx_q[2], rx_q[3], rx_q[4]};
  assign ans_idx = (count_q < 3'd5) ? count_q : 3'd4;
  assign mem_we = (state_q == ST_FIN) && rx_q[0][7] && (addr != ADDR_GSTAT);

  always_comb begin
    rval = 32'd0;
    if (addr == ADDR_GSTAT) begin
      rval[2] = uv_q;
    end else if (addr == ADDR_IOIN) begin
      if (ident_q) rval = IOIN_IDENTITY;
      rval[0] = step_q;
      rval[1] = dir_q;
      rval[4] = !en_q;
    end else if (addr == ADDR_DRV_STATUS) begin
      rval[28:27] = {fault_q, fault_q};
      rval[26] = otw_q;
      rval[25] = ot_q;
    end else if (rd_valid_q) begin
      rval = rd_q;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (accept && opcode == OP_CS_DEASSERT && selected_q && count_q == 3'd5
                   && present_q) state_d = ST_FIN;
      ST_FIN:  state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[addr] <= wval;
    rd_q <= mem[addr];
    rd_valid_q <= valid_q[addr];
  end

  always_ff @(posedge clk_i) begin
    if (accept && opcode == OP_CS_DEASSERT) begin
      step_q  <= s_axis_tdata[10];
      dir_q   <= s_axis_tdata[11];
      en_q    <= s_axis_tdata[12];
      fault_q <= s_axis_tdata[13];
      ot_q    <= s_axis_tdata[14];
      otw_q   <= s_axis_tdata[15];
      uvset_q <= s_axis_tdata[16];
    end
    if (accept && opcode == OP_XFER && selected_q && present_q && count_q < 3'd5) begin
      rx_q[count_q] <= mosi;
    end
    if (accept && opcode == OP_XFER) begin
      out_data_q <= (selected_q && present_q) ? ans_q[ans_idx] : MISO_IDLE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      present_q   <= 1'b1;
      ident_q     <= 1'b1;
      selected_q  <= 1'b0;
      count_q     <= 3'd0;
      uv_q        <= 1'b0;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < DgBytes; i++) begin
        ans_q[i]  <= 8'd0;
        pend_q[i] <= 8'd0;
      end
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_DEVICE_PRESENT: present_q <= cfg_data_i[0];
          CFG_VALID_IDENTITY: ident_q   <= cfg_data_i[0];
          default: ;
        endcase
      end
      if (m_axis_tready) out_valid_q <= 1'b0;
      if (accept) begin
        unique case (opcode)
          OP_CS_ASSERT: begin
            if (!selected_q) begin
              count_q <= 3'd0;
              for (int i = 0; i < DgBytes; i++) begin
                ans_q[i]  <= pend_q[i];
                pend_q[i] <= 8'd0;
              end
            end
            selected_q <= 1'b1;
          end
          OP_CS_DEASSERT: selected_q <= 1'b0;
          OP_XFER: begin
            out_valid_q <= 1'b1;
            if (selected_q && present_q && count_q < 3'd5) count_q <= count_q + 3'd1;
          end
          default: ;
        endcase
        // deassert applies the undervoltage set after the register access
        if (s_axis_tdata[16] && !(opcode == OP_CS_DEASSERT && state_d == ST_FIN)) begin
          uv_q <= 1'b1;
        end
      end
      if (state_q == ST_FIN) begin
        if (rx_q[0][7]) begin
          if (addr == ADDR_GSTAT) begin
            if (wval[2]) uv_q <= 1'b0;
          end else begin
            valid_q[addr] <= 1'b1;
          end
        end else begin
          pend_q[0] <= fault_q ? STATUS_FAULT : 8'd0;
          pend_q[1] <= rval[31:24];
          pend_q[2] <= rval[23:16];
          pend_q[3] <= rval[15:8];
          pend_q[4] <= rval[7:0];
        end
        if (uvset_q) uv_q <= 1'b1;
      end
    end
  end

endmodule
